/* rtl/wnpt_pkg.sv */
// shared types and constants for the windowed nearest point table
package wnpt_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
    localparam int MAX_RESULTS   = 8;
    localparam int IDX_W         = $clog2(MAX_RESULTS);
    localparam int CNT_W         = IDX_W + 1;
    localparam int COORD_W       = 24;
    localparam int LIMIT_W       = 23;
    localparam int TAG_W         = 32;
    localparam int DIST_W        = 48;
    localparam int MM_W          = 4;
    localparam int ENTRY_W       = 2 * COORD_W + TAG_W;
    localparam int PADDR_W       = 3;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 23'd2560;
    localparam logic [MM_W-1:0]    MM_RESET    = 4'd5;

    typedef enum logic [0:0] {
        REG_DISTANCE_LIMIT = 1'b0,
        REG_MAX_MATCHES    = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_QUERY  = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_DUP       = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [1:0]                mode;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic [TAG_W-1:0]          trip_tag;
    } t_in_word;

    typedef struct packed {
        logic [1:0]        status;
        logic              match_found;
        logic [TAG_W-1:0]  match_tag;
        logic [DIST_W-1:0] dist_squared;
        logic              last;
    } t_out_word;

    // candidate entry leaving the distance pipeline
    typedef struct packed {
        logic              vld;
        logic [DIST_W-1:0] dsq;
        logic [TAG_W-1:0]  tag;
    } t_cand;

endpackage

/* rtl/wnpt_ram.sv */
// generic single port ram with registered read
module wnpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/wnpt_dist.sv */
// window check and squared distance pipeline, three register stages
module wnpt_dist (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_vld,
    input  logic signed [wnpt_pkg::COORD_W-1:0] i_px,
    input  logic signed [wnpt_pkg::COORD_W-1:0] i_py,
    input  logic signed [wnpt_pkg::COORD_W-1:0] i_ex,
    input  logic signed [wnpt_pkg::COORD_W-1:0] i_ey,
    input  logic [wnpt_pkg::TAG_W-1:0]        i_tag,
    input  logic [wnpt_pkg::LIMIT_W-1:0]      i_limit,
    output wnpt_pkg::t_cand                   o_cand,
    output logic                              o_busy
);
    import wnpt_pkg::*;

    logic signed [COORD_W:0] dx, dy;
    logic [COORD_W:0]        ax, ay;
    logic                    in_win;

    logic                 r_s1_vld, r_s2_vld, r_s3_vld;
    logic [LIMIT_W-1:0]   r_s1_ax, r_s1_ay;
    logic [TAG_W-1:0]     r_s1_tag, r_s2_tag, r_s3_tag;
    logic [2*LIMIT_W-1:0] r_s2_xx, r_s2_yy;
    logic [DIST_W-1:0]    r_s3_d;

    always_comb begin
        dx = {i_px[COORD_W-1], i_px} - {i_ex[COORD_W-1], i_ex};
        dy = {i_py[COORD_W-1], i_py} - {i_ey[COORD_W-1], i_ey};
        ax = dx[COORD_W] ? (COORD_W+1)'(0) - dx : dx;
        ay = dy[COORD_W] ? (COORD_W+1)'(0) - dy : dy;
        in_win = (ax <= {2'b00, i_limit}) && (ay <= {2'b00, i_limit});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_vld && in_win;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
        r_s1_ax  <= ax[LIMIT_W-1:0];
        r_s1_ay  <= ay[LIMIT_W-1:0];
        r_s1_tag <= i_tag;
        r_s2_xx  <= r_s1_ax * r_s1_ax;
        r_s2_yy  <= r_s1_ay * r_s1_ay;
        r_s2_tag <= r_s1_tag;
        r_s3_d   <= DIST_W'(r_s2_xx) + DIST_W'(r_s2_yy);
        r_s3_tag <= r_s2_tag;
    end

    assign o_cand = '{vld: r_s3_vld, dsq: r_s3_d, tag: r_s3_tag};
    assign o_busy = r_s1_vld || r_s2_vld || r_s3_vld;
endmodule

/* rtl/wnpt_sort.sv */
// sorted list of the nearest candidates, ties keep arrival order
module wnpt_sort (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_clear,
    input  wnpt_pkg::t_cand             i_cand,
    input  logic [wnpt_pkg::IDX_W-1:0]  i_rd_idx,
    output logic [wnpt_pkg::CNT_W-1:0]  o_count,
    output logic [wnpt_pkg::DIST_W-1:0] o_rd_dist,
    output logic [wnpt_pkg::TAG_W-1:0]  o_rd_tag
);
    import wnpt_pkg::*;

    logic [DIST_W-1:0]      r_d [MAX_RESULTS];
    logic [TAG_W-1:0]       r_t [MAX_RESULTS];
    logic [CNT_W-1:0]       r_n;
    logic [MAX_RESULTS-1:0] le;

    always_comb begin
        for (int j = 0; j < MAX_RESULTS; j++) begin
            le[j] = (CNT_W'(j) < r_n) && (r_d[j] <= i_cand.dsq);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_n <= '0;
        end else if (i_cand.vld && r_n != CNT_W'(MAX_RESULTS)) begin
            r_n <= r_n + 1'b1;
        end
        if (i_cand.vld) begin
            for (int j = 0; j < MAX_RESULTS; j++) begin
                if (!le[j]) begin
                    if (j == 0 || le[(j == 0) ? 0 : j-1]) begin
                        r_d[j] <= i_cand.dsq;
                        r_t[j] <= i_cand.tag;
                    end else begin
                        r_d[j] <= r_d[(j == 0) ? 0 : j-1];
                        r_t[j] <= r_t[(j == 0) ? 0 : j-1];
                    end
                end
            end
        end
    end

    assign o_count   = r_n;
    assign o_rd_dist = r_d[i_rd_idx];
    assign o_rd_tag  = r_t[i_rd_idx];
endmodule

/* rtl/windowed_nearest_point_table.sv */
// top level: table of tagged points with tag lookup and windowed nearest query
// every word scans all table slots through the point memory, one read per cycle
// a result word follows the scan reads, the memory read stage, three distance stages
//   and the sort list; a query finishes once the distance stages have drained
// a new word is taken only in idle, after the last result word of the previous one is loaded
// reset (synchronous, active low) empties the table and restores the registers
module windowed_nearest_point_table (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  wnpt_pkg::t_in_word             i_in_word,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output wnpt_pkg::t_out_word            o_out_word,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [wnpt_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import wnpt_pkg::*;

    // configuration registers
    logic [LIMIT_W-1:0] r_limit;
    logic [MM_W-1:0]    r_mm;

    // control
    t_state r_state, n_state;

    // latched input word
    logic [1:0]          r_mode;
    logic [COORD_W-1:0]  r_px, r_py;
    logic [TAG_W-1:0]    r_tag;

    // scan address and the stage that holds read data
    logic [ADDR_W-1:0]   r_addr;
    logic                r_issue;
    logic                r_p1_vld;
    logic [ADDR_W-1:0]   r_p1_slot;

    // per slot valid bits, cleared at reset
    logic [TABLE_ENTRIES-1:0] r_valid;

    // tag lookup and first free slot found during the scan
    logic                r_hit, r_free;
    logic [ADDR_W-1:0]   r_hit_slot, r_free_slot;

    // result sequencing
    logic [1:0]          r_status;
    logic [CNT_W-1:0]    r_emit_idx, r_emit_cnt;
    logic                r_out_vld;
    t_out_word           r_out;

    // memory port
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_addr;
    logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;
    logic [COORD_W-1:0]  e_x, e_y;
    logic [TAG_W-1:0]    e_tag;
    logic                e_valid;

    t_cand               cand;
    logic                dist_busy;
    logic [CNT_W-1:0]    lst_n;
    logic [DIST_W-1:0]   lst_dist;
    logic [TAG_W-1:0]    lst_tag;

    logic                in_acc, out_free, emit_load, cfg_wr;
    logic [CNT_W-1:0]    lim, n_cnt;
    logic [1:0]          n_status;
    logic                do_insert, do_remove;

    assign in_acc   = (r_state == ST_IDLE) && i_in_valid;
    assign out_free = !r_out_vld || !i_out_stall;
    assign cfg_wr   = psel && penable && pwrite;

    assign {e_x, e_y, e_tag} = ram_rdata;
    assign e_valid = r_p1_vld && r_valid[r_p1_slot];

    // clamp max_matches into 1..8
    always_comb begin
        if (r_mm == '0) begin
            lim = CNT_W'(1);
        end else if (r_mm > MM_W'(MAX_RESULTS)) begin
            lim = CNT_W'(MAX_RESULTS);
        end else begin
            lim = CNT_W'(r_mm);
        end
        n_cnt = (lst_n < lim) ? lst_n : lim;
    end

    // next state, memory control and finishing decisions
    always_comb begin
        n_state   = r_state;
        ram_we    = 1'b0;
        ram_addr  = r_addr;
        ram_wdata = {r_px, r_py, r_tag};
        n_status  = STAT_OK;
        do_insert = 1'b0;
        do_remove = 1'b0;
        emit_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!r_issue && !r_p1_vld && !dist_busy) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                case (r_mode)
                    MODE_INSERT: begin
                        if (r_hit) begin
                            n_status = STAT_DUP;
                        end else if (r_free) begin
                            do_insert = 1'b1;
                            ram_we    = 1'b1;
                            ram_addr  = r_free_slot;
                        end else begin
                            n_status = STAT_FULL;
                        end
                    end
                    MODE_REMOVE: begin
                        if (r_hit) begin
                            do_remove = 1'b1;
                        end else begin
                            n_status = STAT_NOT_FOUND;
                        end
                    end
                    default: n_status = STAT_OK;
                endcase
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    emit_load = 1'b1;
                    if (r_emit_cnt == '0 || r_emit_idx + 1'b1 == r_emit_cnt) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
            r_mm    <= MM_RESET;
        end else if (cfg_wr) begin
            unique case (t_reg_idx'(paddr[2]))
                REG_DISTANCE_LIMIT: r_limit <= pwdata[LIMIT_W-1:0];
                REG_MAX_MATCHES:    r_mm    <= pwdata[MM_W-1:0];
                default:            r_mm    <= r_mm;
            endcase
        end
    end

    assign prdata = (t_reg_idx'(paddr[2]) == REG_MAX_MATCHES) ?
                    {{(32-MM_W){1'b0}}, r_mm} : {{(32-LIMIT_W){1'b0}}, r_limit};
    assign pready = 1'b1;

    // scan control, lookup and table update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue   <= 1'b0;
            r_p1_vld  <= 1'b0;
            r_valid   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_p1_vld <= r_issue;
            if (in_acc) begin
                r_issue <= 1'b1;
            end else if (r_issue && r_addr == ADDR_W'(TABLE_ENTRIES - 1)) begin
                r_issue <= 1'b0;
            end
            if (do_insert) begin
                r_valid[r_free_slot] <= 1'b1;
            end
            if (do_remove) begin
                r_valid[r_hit_slot] <= 1'b0;
            end
            if (emit_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end

        if (in_acc) begin
            r_mode <= i_in_word.mode;
            r_px   <= i_in_word.pos_x;
            r_py   <= i_in_word.pos_y;
            r_tag  <= i_in_word.trip_tag;
            r_addr <= '0;
            r_hit  <= 1'b0;
            r_free <= 1'b0;
        end else begin
            if (r_issue) begin
                r_addr <= r_addr + 1'b1;
            end
            // first valid slot holding the tag
            if (e_valid && e_tag == r_tag && !r_hit) begin
                r_hit      <= 1'b1;
                r_hit_slot <= r_p1_slot;
            end
            // lowest free slot
            if (r_p1_vld && !r_valid[r_p1_slot] && !r_free) begin
                r_free      <= 1'b1;
                r_free_slot <= r_p1_slot;
            end
        end
        r_p1_slot <= r_addr;

        if (r_state == ST_FIN) begin
            r_status   <= n_status;
            r_emit_idx <= '0;
            r_emit_cnt <= (r_mode == MODE_QUERY) ? n_cnt : '0;
        end else if (emit_load) begin
            r_emit_idx <= r_emit_idx + 1'b1;
        end

        // result word: a match, or the single status word
        if (emit_load) begin
            if (r_emit_cnt == '0) begin
                r_out <= '{status: r_status, match_found: 1'b0, match_tag: '0,
                           dist_squared: '0, last: 1'b1};
            end else begin
                r_out <= '{status: STAT_OK, match_found: 1'b1, match_tag: lst_tag,
                           dist_squared: lst_dist,
                           last: (r_emit_idx + 1'b1 == r_emit_cnt)};
            end
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

    // point memory: x, y and tag of every slot
    wnpt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // window check and squared distance of each valid slot during a query
    wnpt_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (e_valid && r_mode == MODE_QUERY),
        .i_px    (r_px),
        .i_py    (r_py),
        .i_ex    (e_x),
        .i_ey    (e_y),
        .i_tag   (e_tag),
        .i_limit (r_limit),
        .o_cand  (cand),
        .o_busy  (dist_busy)
    );

    // nearest candidates in order, read out while emitting
    wnpt_sort u_sort (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (in_acc),
        .i_cand    (cand),
        .i_rd_idx  (r_emit_idx[IDX_W-1:0]),
        .o_count   (lst_n),
        .o_rd_dist (lst_dist),
        .o_rd_tag  (lst_tag)
    );
endmodule
